### rtl/core/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Holds the command codes, status codes and the fixed field widths.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Fixed widths of the request and response fields.
  localparam int CMD_W  = 2;
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 12;

  // A header word holds a 13-bit payload size and the used bit above it.
  localparam int PSZ_W    = 13;
  localparam int HDR_W    = 14;
  localparam int USED_BIT = 13;

  // Rounded request sizes reach 8192, so they take one bit more than the field.
  localparam int RSZ_W = 14;

  // Running byte count of a free run, with headroom above the largest heap.
  localparam int CNT_W = 15;

  // Largest heap length that a rounded init request can name.
  localparam int MAX_REQ_BYTES = 8192;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  // Status codes.
  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_NO_SPACE = 1'b1;

endpackage

### rtl/core/ffha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_if: request and response channels of the heap allocator
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::CMD_W-1:0]   command;
  logic [ffha_pkg::SIZE_W-1:0]  size_bytes;
  logic [ffha_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output command, output size_bytes, output address,
                  input ready);
  modport sink   (input valid, input command, input size_bytes, input address,
                  output ready);
endinterface

interface ffha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::ADDR_W-1:0]  address_res;
  logic                         status;

  modport source (output valid, output address_res, output status, input ready);
  modport sink   (input valid, input address_res, input status, output ready);
endinterface

### rtl/core/ffha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram: generic single-port RAM with registered read
// One address per cycle; a write or a read, read data valid the next cycle.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port share the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/core/ffha_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_alu: shared three-operand adder with a limit compare
// Every sum and most bound checks of the allocator go through this one unit.
// ----------------------------------------------------------------------------
module ffha_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] c_i,
  input  logic [W-1:0] lim_i,
  output logic [W-1:0] sum_o,
  output logic         ge_o
);

  // The sum wraps at W bits, which also serves subtraction by complement.
  assign sum_o = a_i + b_i + c_i;
  assign ge_o  = (sum_o >= lim_i);

endmodule

### rtl/core/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over an implicit header list
// Init, allocate and free requests on a heap of 4-byte block headers.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields                           Moves when
//  req_i    in   command, size_bytes, address     req_i.valid && req_i.ready
//  rsp_o    out  address_res, status              rsp_o.valid && rsp_o.ready
//
//  Init and free present their response once their own states and S_DONE have
//  run. An allocation visits the headers in turn through S_ACC and S_STEP;
//  the registered read of the header RAM feeds the shared adder for each
//  next header.
//  Reset empties the heap at once; the header RAM needs no clearing pass.
//  One request is in work at a time; the response register lets the next
//  request start while a response waits on a stalled rsp_o.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ffha_req_if.sink         req_i,
  ffha_rsp_if.source       rsp_o
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int HEAP_BYTES_MAX = (HEAP_WORDS * 4 < ffha_pkg::MAX_REQ_BYTES) ?
                                  HEAP_WORDS * 4 : ffha_pkg::MAX_REQ_BYTES;
  localparam int END_W = $clog2(HEAP_BYTES_MAX + 1);
  localparam int EW    = END_W - 2;
  localparam int CMP_W = (END_W > ffha_pkg::ADDR_W) ? END_W : ffha_pkg::ADDR_W;
  localparam int ALU_W = (AW + 3 > 16) ? AW + 3 : 16;

  localparam logic [ALU_W-1:0] ALU_ONE    = ALU_W'(1);
  localparam logic [ALU_W-1:0] ALU_THREE  = ALU_W'(3);
  localparam logic [ALU_W-1:0] ALU_FOUR   = ALU_W'(4);
  localparam logic [ALU_W-1:0] ALU_MINUS4 = ALU_W'(-4);
  localparam logic [ALU_W-1:0] ALU_MINUS7 = ALU_W'(-7);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_INIT_WR = 4'd2;
  localparam logic [3:0] S_ALLOC0  = 4'd3;
  localparam logic [3:0] S_ACC     = 4'd4;
  localparam logic [3:0] S_STEP    = 4'd5;
  localparam logic [3:0] S_WR_USED = 4'd6;
  localparam logic [3:0] S_WR_REM  = 4'd7;
  localparam logic [3:0] S_ADDR    = 4'd8;
  localparam logic [3:0] S_FREE_RD = 4'd9;
  localparam logic [3:0] S_FREE_WR = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]                   state_q, state_d;
  logic [ffha_pkg::ADDR_W-1:0]  addr_in_q, addr_in_d;
  logic [ffha_pkg::RSZ_W-1:0]   size_r_q, size_r_d;
  logic [ffha_pkg::RSZ_W-1:0]   target_q, target_d;
  logic [END_W-1:0]             heap_end_q, heap_end_d;
  logic [AW-1:0]                w_q, w_d;
  logic [AW-1:0]                start_q, start_d;
  logic [ffha_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ffha_pkg::PSZ_W-1:0]   psz_q, psz_d;
  logic [ffha_pkg::PSZ_W-1:0]   rem_q, rem_d;
  logic                         ok_q, ok_d;
  logic [ffha_pkg::ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic                         pend_stat_q, pend_stat_d;
  logic                         out_valid_q, out_valid_d;
  logic [ffha_pkg::ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic                         out_stat_q, out_stat_d;

  logic [ALU_W-1:0]             alu_a, alu_b, alu_c, alu_lim, alu_sum;
  logic                         alu_ge;

  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  logic [ffha_pkg::HDR_W-1:0]   ram_wdata, ram_rdata;

  logic [EW-1:0]                end_words;
  logic                         req_fire;

  assign end_words    = heap_end_q[END_W-1:2];
  assign req_i.ready  = (state_q == S_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.address_res = out_addr_q;
  assign rsp_o.status      = out_stat_q;

  // Shared adder and compare.
  ffha_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .lim_i (alu_lim),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  // Header store.
  ffha_ram #(
    .WIDTH (ffha_pkg::HDR_W),
    .DEPTH (HEAP_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer: operand selection, RAM control and next-state logic.
  always_comb begin
    state_d     = state_q;
    addr_in_d   = addr_in_q;
    size_r_d    = size_r_q;
    target_d    = target_q;
    heap_end_d  = heap_end_q;
    w_d         = w_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    psz_d       = psz_q;
    rem_d       = rem_q;
    ok_d        = ok_q;
    pend_addr_d = pend_addr_q;
    pend_stat_d = pend_stat_q;
    out_addr_d  = out_addr_q;
    out_stat_d  = out_stat_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    alu_a   = '0;
    alu_b   = '0;
    alu_c   = '0;
    alu_lim = '0;

    ram_we    = 1'b0;
    ram_addr  = w_q;
    ram_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        // Round the size up to whole words for every command.
        alu_a = ALU_W'(req_i.size_bytes);
        alu_c = ALU_THREE;
        if (req_fire) begin
          addr_in_d   = req_i.address;
          size_r_d    = {alu_sum[ffha_pkg::RSZ_W-1:2], 2'b00};
          pend_addr_d = '0;
          pend_stat_d = ffha_pkg::STAT_OK;
          case (req_i.command)
            ffha_pkg::CMD_INIT:  state_d = S_INIT;
            ffha_pkg::CMD_ALLOC: state_d = S_ALLOC0;
            ffha_pkg::CMD_FREE:  state_d = S_FREE_RD;
            default:             state_d = S_DONE;
          endcase
        end
      end

      S_INIT: begin
        // Clamp the rounded length to the heap.
        alu_a   = ALU_W'(size_r_q);
        alu_lim = ALU_W'(HEAP_BYTES_MAX + 1);
        if (alu_ge) begin
          heap_end_d = END_W'(HEAP_BYTES_MAX);
        end else begin
          heap_end_d = size_r_q[END_W-1:0];
        end
        state_d = S_INIT_WR;
      end

      S_INIT_WR: begin
        // One free block spans the whole heap.
        alu_a = ALU_W'(heap_end_q);
        alu_c = ALU_MINUS4;
        if (heap_end_q != '0) begin
          ram_we    = 1'b1;
          ram_addr  = '0;
          ram_wdata = {1'b0, alu_sum[ffha_pkg::PSZ_W-1:0]};
        end
        state_d = S_DONE;
      end

      S_ALLOC0: begin
        // Target run length is the rounded size plus one header.
        alu_a = ALU_W'(size_r_q);
        alu_c = ALU_FOUR;
        if (heap_end_q == '0) begin
          pend_stat_d = ffha_pkg::STAT_NO_SPACE;
          state_d     = S_DONE;
        end else begin
          target_d = alu_sum[ffha_pkg::RSZ_W-1:0];
          w_d      = '0;
          cnt_d    = '0;
          ram_addr = '0;
          state_d  = S_ACC;
        end
      end

      S_ACC: begin
        // Add the header at w to the current free run and test the fit.
        psz_d   = ram_rdata[ffha_pkg::PSZ_W-1:0];
        start_d = (cnt_q == '0) ? w_q : start_q;
        alu_a   = ALU_W'(cnt_q);
        alu_b   = ALU_W'(ram_rdata[ffha_pkg::PSZ_W-1:0]);
        alu_c   = ALU_FOUR;
        alu_lim = ALU_W'(target_q);
        if (ram_rdata[ffha_pkg::USED_BIT]) begin
          cnt_d   = '0;
          state_d = S_STEP;
        end else begin
          cnt_d = alu_sum[ffha_pkg::CNT_W-1:0];
          if (alu_ge) begin
            state_d = S_WR_USED;
          end else begin
            state_d = S_STEP;
          end
        end
      end

      S_STEP: begin
        // Advance to the next header and fetch it.
        alu_a   = ALU_W'(w_q);
        alu_b   = ALU_W'(psz_q[ffha_pkg::PSZ_W-1:2]);
        alu_c   = ALU_ONE;
        alu_lim = ALU_W'(end_words);
        if (alu_ge) begin
          pend_stat_d = ffha_pkg::STAT_NO_SPACE;
          state_d     = S_DONE;
        end else begin
          w_d      = alu_sum[AW-1:0];
          ram_addr = alu_sum[AW-1:0];
          state_d  = S_ACC;
        end
      end

      S_WR_USED: begin
        // Mark the run used and work out the remainder payload size.
        ram_we    = 1'b1;
        ram_addr  = start_q;
        ram_wdata = {1'b1, size_r_q[ffha_pkg::PSZ_W-1:0]};
        alu_a     = ALU_W'(cnt_q);
        alu_b     = ~ALU_W'(size_r_q);
        alu_c     = ALU_MINUS7;
        rem_d     = alu_sum[ffha_pkg::PSZ_W-1:0];
        state_d   = S_WR_REM;
      end

      S_WR_REM: begin
        // Split off the leftover bytes as a free block when any remain.
        alu_a   = ALU_W'(start_q);
        alu_b   = ALU_W'(size_r_q[ffha_pkg::RSZ_W-1:2]);
        alu_c   = ALU_ONE;
        alu_lim = ALU_W'(HEAP_WORDS);
        if ((cnt_q != ffha_pkg::CNT_W'(target_q)) && !alu_ge) begin
          ram_we    = 1'b1;
          ram_addr  = alu_sum[AW-1:0];
          ram_wdata = {1'b0, rem_q};
        end
        state_d = S_ADDR;
      end

      S_ADDR: begin
        // Payload starts one header past the block start.
        alu_a       = ALU_W'({start_q, 2'b00});
        alu_c       = ALU_FOUR;
        pend_addr_d = alu_sum[ffha_pkg::ADDR_W-1:0];
        pend_stat_d = ffha_pkg::STAT_OK;
        state_d     = S_ADDR == state_q ? S_DONE : state_q;
      end

      S_FREE_RD: begin
        // Header word sits just below the payload; check the address.
        alu_a    = ALU_W'(addr_in_q[ffha_pkg::ADDR_W-1:2]);
        alu_b    = '1;
        w_d      = alu_sum[AW-1:0];
        ram_addr = alu_sum[AW-1:0];
        ok_d     = (addr_in_q[1:0] == 2'b00) &&
                   (addr_in_q[ffha_pkg::ADDR_W-1:2] != '0) &&
                   (CMP_W'(addr_in_q) <= CMP_W'(heap_end_q));
        state_d  = S_FREE_WR;
      end

      S_FREE_WR: begin
        // Clear the used bit, keep the size.
        if (ok_q) begin
          ram_we    = 1'b1;
          ram_addr  = w_q;
          ram_wdata = {1'b0, ram_rdata[ffha_pkg::PSZ_W-1:0]};
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the response register once it is free.
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_addr_d  = pend_addr_q;
          out_stat_d  = pend_stat_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_end_q  <= heap_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    addr_in_q   <= addr_in_d;
    size_r_q    <= size_r_d;
    target_q    <= target_d;
    w_q         <= w_d;
    start_q     <= start_d;
    cnt_q       <= cnt_d;
    psz_q       <= psz_d;
    rem_q       <= rem_d;
    ok_q        <= ok_d;
    pend_addr_q <= pend_addr_d;
    pend_stat_q <= pend_stat_d;
    out_addr_q  <= out_addr_d;
    out_stat_q  <= out_stat_d;
  end

  // The heap length stays word aligned and inside the heap.
  a_heap_end_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heap_end_q[1:0] == 2'b00) && (heap_end_q <= END_W'(HEAP_BYTES_MAX)))
    else $error("heap length out of bounds");

  // A failed allocation reports a zero offset.
  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ffha_pkg::STAT_NO_SPACE)) |->
    (rsp_o.address_res == '0))
    else $error("failed response with nonzero offset");

  // A taken request blocks the next one in the cycle after it.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request accepted while another is in work");

  // The header store is never written while idle or delivering.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q != S_IDLE) && (state_q != S_DONE)))
    else $error("header write outside of a command");

endmodule
